@@ sv/pkraw_pkg.sv @@
// ============================================================================
// pkraw_pkg
// Types and codes shared by the packet reassembly and ack window tracker.
// ============================================================================
package pkraw_pkg;

    // One packet header as it arrives on the input channel.
    typedef struct packed {
        logic        is_fragment;
        logic [30:0] sequence_req;
        logic [7:0]  frag_id;
        logic [13:0] full_length;
        logic [30:0] ack_sequence;
        logic [13:0] payload_length;
    } pkraw_hdr_t;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [2:0]  status;
        logic        reassembly_started;
        logic        reassembly_done;
        logic [30:0] window_start;
    } pkraw_result_t;

    // Work handed from the classifier to the window engine.
    typedef struct packed {
        logic        take_ack;
        logic [30:0] ack;
        logic [2:0]  status;
        logic        started;
        logic        done;
    } pkraw_cmd_t;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_WRONG_SEQ  = 3'd1;
    localparam logic [2:0] STATUS_NOT_REASM  = 3'd2;
    localparam logic [2:0] STATUS_SKIPPED_ID = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW   = 3'd4;
    localparam logic [2:0] STATUS_ACK_OLD    = 3'd5;

    localparam logic [2:0] SLOT_DROPPED = 3'd3;
    localparam logic [2:0] SLOT_SUCCESS = 3'd4;

endpackage

@@ sv/pkraw_front.sv @@
// ============================================================================
// pkraw_front
// Header classifier: checks fragments against the open reassembly, opens,
// completes and abandons reassemblies, and queues one command per header.
// ============================================================================
module pkraw_front
    import pkraw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       hdr_valid,
    output logic       hdr_stall,
    input  pkraw_hdr_t hdr,
    input  logic       q_full,
    output logic       push,
    output pkraw_cmd_t cmd
);

    logic        reasm_reg, reasm_next;
    logic [30:0] frag_seq_reg, frag_seq_next;
    logic [7:0]  last_fid_reg, last_fid_next;
    logic [13:0] bytes_reg, bytes_next;
    logic [13:0] expected_reg, expected_next;

    logic [8:0]  fid_expect;
    logic [14:0] sum;

    assign hdr_stall  = q_full;
    assign push       = hdr_valid && !q_full;
    assign fid_expect = {1'b0, last_fid_reg} + 9'd1;
    assign sum        = {1'b0, bytes_reg} + {1'b0, hdr.payload_length};

    always_comb
    begin
        reasm_next    = reasm_reg;
        frag_seq_next = frag_seq_reg;
        last_fid_next = last_fid_reg;
        bytes_next    = bytes_reg;
        expected_next = expected_reg;
        cmd.take_ack  = !hdr.is_fragment;
        cmd.ack       = hdr.ack_sequence;
        cmd.status    = STATUS_OK;
        cmd.started   = 1'b0;
        cmd.done      = 1'b0;
        if (hdr.is_fragment)
        begin
            if (!reasm_reg)
            begin
                cmd.status = STATUS_NOT_REASM;
            end
            else if (frag_seq_reg != hdr.sequence_req)
            begin
                cmd.status = STATUS_WRONG_SEQ;
            end
            else if ({1'b0, hdr.frag_id} != fid_expect)
            begin
                cmd.status = STATUS_SKIPPED_ID;
            end
            else
            begin
                // The fragment number is kept even when the length overflows.
                last_fid_next = hdr.frag_id;
                if (sum > {1'b0, expected_reg})
                begin
                    cmd.status = STATUS_OVERFLOW;
                end
                else
                begin
                    bytes_next = sum[13:0];
                    if (sum[13:0] == expected_reg)
                    begin
                        reasm_next = 1'b0;
                        cmd.done   = 1'b1;
                    end
                end
            end
        end
        else if (reasm_reg)
        begin
            // A new first packet abandons the message in progress.
            reasm_next    = 1'b0;
            bytes_next    = '0;
            expected_next = '0;
        end
        else if (hdr.full_length > hdr.payload_length)
        begin
            reasm_next    = 1'b1;
            expected_next = hdr.full_length;
            bytes_next    = hdr.payload_length;
            frag_seq_next = hdr.sequence_req;
            last_fid_next = '0;
            cmd.started   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reasm_reg    <= 1'b0;
            frag_seq_reg <= '0;
            last_fid_reg <= '0;
            bytes_reg    <= '0;
            expected_reg <= '0;
        end
        else if (push)
        begin
            reasm_reg    <= reasm_next;
            frag_seq_reg <= frag_seq_next;
            last_fid_reg <= last_fid_next;
            bytes_reg    <= bytes_next;
            expected_reg <= expected_next;
        end
    end

endmodule

@@ sv/pkraw_fifo.sv @@
// ============================================================================
// pkraw_fifo
// Two-entry command queue between the classifier and the window engine.
// ============================================================================
module pkraw_fifo
    import pkraw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pkraw_cmd_t push_data,
    output logic       full,
    input  logic       pop,
    output pkraw_cmd_t pop_data,
    output logic       empty
);

    pkraw_cmd_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/pkraw_back.sv @@
// ============================================================================
// pkraw_back
// Window engine: refuses stale acks, sweeps dropped slots one per cycle,
// marks the acked slot and holds the result register.
// ============================================================================
module pkraw_back
    import pkraw_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  pkraw_cmd_t    cmd,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output pkraw_result_t result
);

    localparam int IW = $clog2(WINDOW_SIZE);
    localparam int CW = $clog2(WINDOW_SIZE + 1);
    localparam logic [3:0] MOD_STEPS = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } back_state_t;

    back_state_t   state_reg, state_next;
    logic [30:0]   oldest_reg, oldest_next;
    logic [IW-1:0] oldest_idx_reg, oldest_idx_next;
    logic [30:0]   ack_reg, ack_next;
    logic          started_reg, started_next;
    logic [30:0]   sweep_seq_reg, sweep_seq_next;
    logic [IW-1:0] sweep_idx_reg, sweep_idx_next;
    logic [CW-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic [31:0]   mod_src_reg, mod_src_next;
    logic [IW-1:0] mod_rem_reg, mod_rem_next;
    logic [3:0]    mod_cnt_reg, mod_cnt_next;
    logic          out_valid_reg, out_valid_next;
    pkraw_result_t out_data_reg, out_data_next;
    logic          out_load;

    logic [2:0]             slot_mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] slot_valid_reg;
    logic                   slot_we;
    logic [IW-1:0]          slot_waddr;
    logic [2:0]             slot_wdata;

    logic out_free;
    logic sweep_busy;
    logic mod_busy;

    // Four remainder steps of a restoring reduction modulo the window size.
    function automatic logic [IW-1:0] mod_digit(input logic [IW-1:0] rem,
                                                input logic [3:0]    digit);
        logic [IW:0]   t;
        logic [IW-1:0] acc;
        acc = rem;
        for (int b = 3; b >= 0; b--)
        begin
            t = {acc, digit[b]};
            if (t >= (IW+1)'(WINDOW_SIZE))
            begin
                t = t - (IW+1)'(WINDOW_SIZE);
            end
            acc = t[IW-1:0];
        end
        return acc;
    endfunction

    assign out_free     = !out_valid_reg || !result_stall;
    assign pop          = (state_reg == ST_IDLE) && !q_empty && out_free;
    assign sweep_busy   = (sweep_seq_reg != ack_reg) && (sweep_cnt_reg != CW'(WINDOW_SIZE));
    assign mod_busy     = (mod_cnt_reg != 4'd0);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        oldest_idx_next = oldest_idx_reg;
        ack_next        = ack_reg;
        started_next    = started_reg;
        sweep_seq_next  = sweep_seq_reg;
        sweep_idx_next  = sweep_idx_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        mod_src_next    = mod_src_reg;
        mod_rem_next    = mod_rem_reg;
        mod_cnt_next    = mod_cnt_reg;
        out_load        = 1'b0;
        out_data_next   = out_data_reg;
        slot_we         = 1'b0;
        slot_waddr      = sweep_idx_reg;
        slot_wdata      = SLOT_DROPPED;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (!cmd.take_ack)
                    begin
                        out_load      = 1'b1;
                        out_data_next = '{status: cmd.status,
                                          reassembly_started: 1'b0,
                                          reassembly_done: cmd.done,
                                          window_start: oldest_reg};
                    end
                    else if (cmd.ack < oldest_reg)
                    begin
                        out_load      = 1'b1;
                        out_data_next = '{status: STATUS_ACK_OLD,
                                          reassembly_started: cmd.started,
                                          reassembly_done: 1'b0,
                                          window_start: oldest_reg};
                    end
                    else
                    begin
                        state_next     = ST_WORK;
                        ack_next       = cmd.ack;
                        started_next   = cmd.started;
                        sweep_seq_next = oldest_reg;
                        sweep_idx_next = oldest_idx_reg;
                        sweep_cnt_next = '0;
                        mod_src_next   = {1'b0, cmd.ack};
                        mod_rem_next   = '0;
                        mod_cnt_next   = MOD_STEPS;
                    end
                end
            end
            ST_WORK:
            begin
                if (sweep_busy)
                begin
                    slot_we        = 1'b1;
                    sweep_seq_next = sweep_seq_reg + 31'd1;
                    sweep_cnt_next = sweep_cnt_reg + CW'(1);
                    sweep_idx_next = (sweep_idx_reg == IW'(WINDOW_SIZE - 1)) ?
                                     '0 : sweep_idx_reg + IW'(1);
                end
                if (mod_busy)
                begin
                    mod_rem_next = mod_digit(mod_rem_reg, mod_src_reg[31:28]);
                    mod_src_next = {mod_src_reg[27:0], 4'd0};
                    mod_cnt_next = mod_cnt_reg - 4'd1;
                end
                if (!sweep_busy && !mod_busy && out_free)
                begin
                    slot_we         = 1'b1;
                    slot_waddr      = mod_rem_reg;
                    slot_wdata      = SLOT_SUCCESS;
                    oldest_next     = ack_reg;
                    oldest_idx_next = mod_rem_reg;
                    out_load        = 1'b1;
                    out_data_next   = '{status: STATUS_OK,
                                        reassembly_started: started_reg,
                                        reassembly_done: 1'b0,
                                        window_start: ack_reg};
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            oldest_reg     <= '0;
            oldest_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            oldest_idx_reg <= oldest_idx_next;
            out_valid_reg  <= out_valid_next;
            if (slot_we)
            begin
                slot_valid_reg[slot_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ack_reg       <= ack_next;
        started_reg   <= started_next;
        sweep_seq_reg <= sweep_seq_next;
        sweep_idx_reg <= sweep_idx_next;
        sweep_cnt_reg <= sweep_cnt_next;
        mod_src_reg   <= mod_src_next;
        mod_rem_reg   <= mod_rem_next;
        mod_cnt_reg   <= mod_cnt_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
    end

endmodule

@@ sv/packet_reassembly_and_ack_window.sv @@
// ============================================================================
// packet_reassembly_and_ack_window
// Receive-side reassembly tracker and acknowledgement window for one packet
// header per transfer.
// ============================================================================
//
//  Channel   Signals                          Direction  Transfer carries
//  -------   -------------------------------  ---------  ----------------------
//  header    hdr_valid, hdr_stall, hdr        in         one packet header
//  result    result_valid, result_stall,      out        status, flags and the
//            result                                      window start
//
// For a first packet whose ack is accepted, the dropped-slot sweep marks at
// most WINDOW_SIZE slots, writing one slot per cycle, and the slot index of
// the ack is reduced four bits per cycle alongside it. Reset is asynchronous
// and active low and empties the queue, the result register and the slot
// valid bits. The header side stalls only when the two-entry queue is full;
// the result side holds its transfer for as long as result_stall is high.
//
module packet_reassembly_and_ack_window
    import pkraw_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hdr_valid,
    output logic          hdr_stall,
    input  pkraw_hdr_t    hdr,
    output logic          result_valid,
    input  logic          result_stall,
    output pkraw_result_t result
);

    // Commands flow front -> queue -> back, one per accepted header.
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    pkraw_cmd_t front_cmd;
    pkraw_cmd_t back_cmd;

    // The front owns the reassembly state and classifies each header. Its
    // updates happen at the header transfer, so later headers always see
    // the state left by earlier ones.
    pkraw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_stall (hdr_stall),
        .hdr       (hdr),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (front_cmd)
    );

    // The queue lets the front keep taking headers while the back sweeps.
    pkraw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (back_cmd),
        .empty     (q_empty)
    );

    // The back owns the window start and the slot table, and produces the
    // result for every command in queue order.
    pkraw_back #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .cmd          (back_cmd),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ sv/pkraw_checker.sv @@
// ============================================================================
// pkraw_checker
// Port-level checks for the reassembly and ack window tracker.
// ============================================================================
module pkraw_checker
    import pkraw_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          hdr_valid,
    input logic          hdr_stall,
    input pkraw_hdr_t    hdr,
    input logic          result_valid,
    input logic          result_stall,
    input pkraw_result_t result
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // Only the six defined status codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status != 3'd6) && (result.status != 3'd7))
        else $error("undefined status code");

    // A header cannot both open and complete a message.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.reassembly_started && result.reassembly_done))
        else $error("started and done together");

    // Refused fragments never flag anything.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.status == STATUS_WRONG_SEQ) ||
                         (result.status == STATUS_NOT_REASM) ||
                         (result.status == STATUS_SKIPPED_ID))
        |-> !result.reassembly_started && !result.reassembly_done)
        else $error("refused fragment raised a flag");

endmodule

bind packet_reassembly_and_ack_window pkraw_checker u_pkraw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .hdr_valid    (hdr_valid),
    .hdr_stall    (hdr_stall),
    .hdr          (hdr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
